@@ rtl/mssd_pkg.sv @@
// ----------------------------------------------------------------------------
// mssd_pkg - shared types and constants of the masked SSD cost/force block
// Field widths, fixed-point shifts, the queue entry layout and register map.
// ----------------------------------------------------------------------------
package mssd_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_PIXEL_BITS = 16;
  localparam int DEF_COUNT_BITS = 24;

  // Fixed field widths
  localparam int GRAD_W  = 16;  // Q8.8 gradient
  localparam int SUM_W   = 58;  // running sum of squared differences
  localparam int FORCE_W = 32;  // Q16.16 force
  localparam int COST_W  = 40;  // unsigned Q.8 cost

  // Fixed-point scaling applied ahead of the division
  localparam int FORCE_SHIFT = 8;  // Q8.8 * int -> Q16.16
  localparam int COST_SHIFT  = 7;  // 0.5 * Q.8

  // Divider sizing: the cost dividend is the widest one
  localparam int DIV_W = SUM_W + COST_SHIFT;
  localparam int QUO_W = COST_W + 1;
  localparam int CNT_W = $clog2(DIV_W + 1);

  localparam logic [FORCE_W-1:0] FORCE_POS_LIM = {1'b0, {(FORCE_W-1){1'b1}}};
  localparam logic [FORCE_W-1:0] FORCE_NEG_LIM = {1'b1, {(FORCE_W-1){1'b0}}};

  // Queue between the front and back ends
  localparam int QUEUE_DEPTH = 4;

  // Stream widths
  localparam int OUT_TDATA_W = 3 * FORCE_W + COST_W;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_IMAGE_SIZE = '0;

  // Per-item flags carried with each queued item
  typedef struct packed {
    logic last;
    logic neg_z;
    logic neg_y;
    logic neg_x;
  } item_flags_t;

  localparam int FLAG_W = $bits(item_flags_t);

  // Queue entry: {sum, mag_z, mag_y, mag_x, flags}
  function automatic int entry_width(input int pixel_bits);
    return SUM_W + 3 * (pixel_bits + GRAD_W) + FLAG_W;
  endfunction

  function automatic int in_tdata_width(input int pixel_bits);
    return ((2 * pixel_bits + 3 * GRAD_W + 7) / 8) * 8;
  endfunction

endpackage

@@ rtl/masked_ssd_cost_and_force_top.sv @@
// ----------------------------------------------------------------------------
// masked_ssd_cost_and_force_top - masked SSD cost and force, one pixel per item
// Each pixel takes three force divisions in the back end, and the last pixel
//   of an image a cost division as well. The back end takes a new item only
//   once done with the previous one, and skips division when image_size is 0.
//   The shared bit-serial divider, one quotient bit per cycle, sets the rate.
// Reset: synchronous, active high; clears the sum, image_size and all valids.
// ----------------------------------------------------------------------------
module masked_ssd_cost_and_force_top
  import mssd_pkg::*;
#(
  parameter int PIXEL_BITS = DEF_PIXEL_BITS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // input stream
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // s_tdata, low to high: pixel_a, pixel_b, grad_x, grad_y, grad_z, zero pad
  input  logic [in_tdata_width(PIXEL_BITS)-1:0] s_tdata,
  // s_tuser: mask_on
  input  logic                                  s_tuser,
  input  logic                                  s_tlast,
  // result stream
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // m_tdata, low to high: force_x, force_y, force_z, cost_value
  output logic [OUT_TDATA_W-1:0]                m_tdata,
  output logic                                  m_tlast,
  // configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [PADDR_W-1:0]                    paddr,
  input  logic [PDATA_W-1:0]                    pwdata,
  output logic [PDATA_W-1:0]                    prdata,
  output logic                                  pready
);

  localparam int NW      = COUNT_BITS + 1;
  localparam int ENTRY_W = entry_width(PIXEL_BITS);
  localparam int PB      = PIXEL_BITS;

  logic [NW-1:0]              image_size;
  logic                       cfg_wr;

  logic                       push_valid, push_ready;
  logic [ENTRY_W-1:0]         push_data;
  logic                       pop_valid, pop_ready;
  logic [ENTRY_W-1:0]         pop_data;

  logic signed [FORCE_W-1:0]  force_x, force_y, force_z;
  logic [COST_W-1:0]          cost_value;
  logic                       cost_ready;

  // ---------------------------------------------------------------------
  // Configuration: a single register, image_size, at byte address 0.
  // Writes land on the access cycle; no wait states.
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_size <= '0;
    end else if (cfg_wr && paddr[PADDR_W-1:2] == REG_IMAGE_SIZE) begin
      image_size <= pwdata[NW-1:0];
    end
  end

  always_comb begin
    if (paddr[PADDR_W-1:2] == REG_IMAGE_SIZE) begin
      prdata = PDATA_W'(image_size);
    end else begin
      prdata = '0;
    end
  end

  // ---------------------------------------------------------------------
  // Front end: difference, products and running sum, two register stages.
  // It keeps accepting pixels while the back end is busy, until the queue
  // fills up.
  // ---------------------------------------------------------------------
  mssd_front #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .pixel_a    (s_tdata[PB-1:0]),
    .pixel_b    (s_tdata[2*PB-1:PB]),
    .mask_on    (s_tuser),
    .grad_x     (s_tdata[2*PB +: GRAD_W]),
    .grad_y     (s_tdata[2*PB+GRAD_W +: GRAD_W]),
    .grad_z     (s_tdata[2*PB+2*GRAD_W +: GRAD_W]),
    .last_pixel (s_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // ---------------------------------------------------------------------
  // Decoupling queue: holds product magnitudes, signs, last flag and the
  // running sum including that pixel, used for the cost at the last pixel.
  // ---------------------------------------------------------------------
  mssd_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  (push_data),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_data  (pop_data)
  );

  // ---------------------------------------------------------------------
  // Back end: serial divisions by image_size, saturation, result register.
  // The result register lets the back end finish while the sink stalls.
  // ---------------------------------------------------------------------
  mssd_back #(
    .PIXEL_BITS (PIXEL_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .image_size (image_size),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .force_x    (force_x),
    .force_y    (force_y),
    .force_z    (force_z),
    .cost_value (cost_value),
    .cost_ready (cost_ready)
  );

  // Pack the result item; cost_ready rides on tlast
  assign m_tdata = {cost_value, force_z, force_y, force_x};
  assign m_tlast = cost_ready;

endmodule

@@ rtl/mssd_front.sv @@
// ----------------------------------------------------------------------------
// mssd_front - input pipeline of the masked SSD cost/force block
// Forms the masked difference, its square and the gradient products, keeps
// the running sum, and pushes one entry per pixel into the queue.
// ----------------------------------------------------------------------------
module mssd_front
  import mssd_pkg::*;
#(
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [PIXEL_BITS-1:0]           pixel_a,
  input  logic signed [PIXEL_BITS-1:0]           pixel_b,
  input  logic                                   mask_on,
  input  logic signed [GRAD_W-1:0]               grad_x,
  input  logic signed [GRAD_W-1:0]               grad_y,
  input  logic signed [GRAD_W-1:0]               grad_z,
  input  logic                                   last_pixel,
  output logic                                   push_valid,
  input  logic                                   push_ready,
  output logic [entry_width(PIXEL_BITS)-1:0]     push_data
);

  localparam int DELTA_W = PIXEL_BITS + 1;
  localparam int MAG_W   = PIXEL_BITS + GRAD_W;
  localparam int PROD_W  = DELTA_W + GRAD_W;
  localparam int SQ_W    = 2 * PIXEL_BITS + 1;

  // Stage A: difference
  logic                      a_valid;
  logic signed [DELTA_W-1:0] a_delta;
  logic [DELTA_W-1:0]        a_dabs;
  logic signed [GRAD_W-1:0]  a_gx, a_gy, a_gz;
  logic                      a_last;

  // Stage B: products
  logic                      b_valid;
  logic signed [PROD_W-1:0]  b_px, b_py, b_pz;
  logic [SQ_W-1:0]           b_sq;
  logic                      b_last;

  logic [SUM_W-1:0]          sum;

  logic                      b_free, a_free, move_a, move_b;
  logic signed [DELTA_W-1:0] delta_raw;
  logic [DELTA_W-1:0]        dabs_raw;
  logic [PROD_W-1:0]         abs_x, abs_y, abs_z;
  logic [SUM_W:0]            sum_add;
  logic [SUM_W-1:0]          sum_new;
  item_flags_t               flags;

  assign move_b   = b_valid && push_ready;
  assign b_free   = !b_valid || push_ready;
  assign move_a   = a_valid && b_free;
  assign a_free   = !a_valid || b_free;
  assign in_ready = a_free;

  always_comb begin
    delta_raw = DELTA_W'(pixel_a) - DELTA_W'(pixel_b);
    dabs_raw  = delta_raw[DELTA_W-1] ? DELTA_W'(-delta_raw) : DELTA_W'(delta_raw);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_free) begin
      a_valid <= in_valid;
    end
    if (a_free && in_valid) begin
      // unmasked pixels carry a zero difference: zero force, nothing summed
      a_delta <= mask_on ? delta_raw : '0;
      a_dabs  <= mask_on ? dabs_raw : '0;
      a_gx    <= grad_x;
      a_gy    <= grad_y;
      a_gz    <= grad_z;
      a_last  <= last_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_free) begin
      b_valid <= a_valid;
    end
    if (move_a) begin
      b_px   <= PROD_W'(a_delta * a_gx);
      b_py   <= PROD_W'(a_delta * a_gy);
      b_pz   <= PROD_W'(a_delta * a_gz);
      b_sq   <= SQ_W'(a_dabs * a_dabs);
      b_last <= a_last;
    end
  end

  // Push stage: magnitudes, saturating accumulate
  always_comb begin
    abs_x   = b_px[PROD_W-1] ? PROD_W'(-b_px) : PROD_W'(b_px);
    abs_y   = b_py[PROD_W-1] ? PROD_W'(-b_py) : PROD_W'(b_py);
    abs_z   = b_pz[PROD_W-1] ? PROD_W'(-b_pz) : PROD_W'(b_pz);
    sum_add = {1'b0, sum} + (SUM_W+1)'(b_sq);
    sum_new = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
    flags.last  = b_last;
    flags.neg_x = b_px[PROD_W-1];
    flags.neg_y = b_py[PROD_W-1];
    flags.neg_z = b_pz[PROD_W-1];
  end

  assign push_valid = b_valid;
  assign push_data  = {sum_new, abs_z[MAG_W-1:0], abs_y[MAG_W-1:0], abs_x[MAG_W-1:0], flags};

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (move_b) begin
      // clear on the last pixel after its snapshot went into the queue
      sum <= b_last ? '0 : sum_new;
    end
  end

endmodule

@@ rtl/mssd_queue.sv @@
// ----------------------------------------------------------------------------
// mssd_queue - small FIFO between the front and back ends
// Register-based, first-word fall-through.
// ----------------------------------------------------------------------------
module mssd_queue
  import mssd_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_Q = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_Q-1:0] count;
  logic             do_wr, do_rd;

  assign wr_ready = (count != CNT_Q'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/mssd_back.sv @@
// ----------------------------------------------------------------------------
// mssd_back - division sequencer and result register
// One bit-serial restoring divider runs the three force quotients and, on
// the last pixel, the cost quotient; results are saturated and registered.
// ----------------------------------------------------------------------------
module mssd_back
  import mssd_pkg::*;
#(
  parameter int PIXEL_BITS = DEF_PIXEL_BITS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [COUNT_BITS:0]                 image_size,
  input  logic                                pop_valid,
  output logic                                pop_ready,
  input  logic [entry_width(PIXEL_BITS)-1:0]  pop_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [FORCE_W-1:0]           force_x,
  output logic signed [FORCE_W-1:0]           force_y,
  output logic signed [FORCE_W-1:0]           force_z,
  output logic [COST_W-1:0]                   cost_value,
  output logic                                cost_ready
);

  localparam int NW     = COUNT_BITS + 1;
  localparam int MAG_W  = PIXEL_BITS + GRAD_W;
  localparam int FSTEPS = MAG_W + FORCE_SHIFT;
  localparam int PAD_W  = DIV_W - FSTEPS;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOAD  = 5'b00010,
    S_DIV   = 5'b00100,
    S_STORE = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    JOB_X,
    JOB_Y,
    JOB_Z,
    JOB_COST
  } job_t;

  state_t              state;
  job_t                job;
  item_flags_t         e_flags;
  logic [MAG_W-1:0]    e_mag_x, e_mag_y, e_mag_z;
  logic [SUM_W-1:0]    e_sum;
  logic [DIV_W-1:0]    shreg;
  logic [NW-1:0]       rem;
  logic [QUO_W-1:0]    quo;
  logic                ovf;
  logic [CNT_W-1:0]    cnt;
  logic [FORCE_W-1:0]  res_x, res_y, res_z;
  logic [COST_W-1:0]   res_cost;

  logic [NW:0]         rem_sh;
  logic                ge;
  logic [NW-1:0]       rem_next;
  logic [MAG_W-1:0]    mag_sel;
  logic                neg_sel;
  logic [FORCE_W-1:0]  force_res;
  logic [COST_W-1:0]   cost_res;
  logic                out_load;

  function automatic logic [FORCE_W-1:0] sat_force(input logic [QUO_W-1:0] q,
                                                   input logic ovf_in,
                                                   input logic neg);
    logic [FORCE_W-1:0] r;
    if (neg) begin
      if (ovf_in || q > QUO_W'(FORCE_NEG_LIM)) begin
        r = FORCE_NEG_LIM;
      end else begin
        r = FORCE_W'(0) - q[FORCE_W-1:0];
      end
    end else begin
      if (ovf_in || q > QUO_W'(FORCE_POS_LIM)) begin
        r = FORCE_POS_LIM;
      end else begin
        r = q[FORCE_W-1:0];
      end
    end
    return r;
  endfunction

  assign pop_ready = (state == S_IDLE);
  assign out_load  = (state == S_OUT) && (!out_valid || out_ready);

  // One restoring-division step
  always_comb begin
    rem_sh   = {rem, shreg[DIV_W-1]};
    ge       = (rem_sh >= {1'b0, image_size});
    rem_next = ge ? NW'(rem_sh - {1'b0, image_size}) : rem_sh[NW-1:0];
  end

  always_comb begin
    unique case (job)
      JOB_X: begin
        mag_sel = e_mag_x;
        neg_sel = e_flags.neg_x;
      end
      JOB_Y: begin
        mag_sel = e_mag_y;
        neg_sel = e_flags.neg_y;
      end
      JOB_Z: begin
        mag_sel = e_mag_z;
        neg_sel = e_flags.neg_z;
      end
      default: begin
        mag_sel = '0;
        neg_sel = 1'b0;
      end
    endcase
    force_res = sat_force(quo, ovf, neg_sel);
    cost_res  = (ovf || quo[QUO_W-1]) ? {COST_W{1'b1}} : quo[COST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      job   <= JOB_X;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (pop_valid) begin
            job   <= JOB_X;
            // a zero image size yields all-zero results with no division
            state <= (image_size == '0) ? S_OUT : S_LOAD;
          end
        end
        S_LOAD: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (cnt == '0) begin
            state <= S_STORE;
          end
        end
        S_STORE: begin
          if (job == JOB_COST || (job == JOB_Z && !e_flags.last)) begin
            state <= S_OUT;
          end else begin
            job   <= job_t'(job + 1'b1);
            state <= S_LOAD;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (state == S_IDLE && pop_valid) begin
      e_flags  <= pop_data[FLAG_W-1:0];
      e_mag_x  <= pop_data[FLAG_W +: MAG_W];
      e_mag_y  <= pop_data[FLAG_W + MAG_W +: MAG_W];
      e_mag_z  <= pop_data[FLAG_W + 2*MAG_W +: MAG_W];
      e_sum    <= pop_data[FLAG_W + 3*MAG_W +: SUM_W];
      res_x    <= '0;
      res_y    <= '0;
      res_z    <= '0;
      res_cost <= '0;
    end
    if (state == S_LOAD) begin
      rem <= '0;
      quo <= '0;
      ovf <= 1'b0;
      if (job == JOB_COST) begin
        shreg <= {e_sum, {COST_SHIFT{1'b0}}};
        cnt   <= CNT_W'(DIV_W - 1);
      end else begin
        shreg <= {mag_sel, {FORCE_SHIFT{1'b0}}, {PAD_W{1'b0}}};
        cnt   <= CNT_W'(FSTEPS - 1);
      end
    end
    if (state == S_DIV) begin
      rem   <= rem_next;
      quo   <= {quo[QUO_W-2:0], ge};
      ovf   <= ovf | quo[QUO_W-1];
      shreg <= {shreg[DIV_W-2:0], 1'b0};
      cnt   <= cnt - 1'b1;
    end
    if (state == S_STORE) begin
      unique case (job)
        JOB_X:    res_x    <= force_res;
        JOB_Y:    res_y    <= force_res;
        JOB_Z:    res_z    <= force_res;
        default:  res_cost <= cost_res;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      force_x    <= res_x;
      force_y    <= res_y;
      force_z    <= res_z;
      cost_value <= res_cost;
      cost_ready <= e_flags.last;
    end
  end

endmodule

@@ rtl/mssd_checker.sv @@
// ----------------------------------------------------------------------------
// mssd_checker - port-level checks for the masked SSD cost/force block
// Watches the stream ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module mssd_checker
  import mssd_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic                   m_tlast
);

  // no result survives a reset
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // cost is only reported on the last pixel of an image
  a_cost_on_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[OUT_TDATA_W-1 -: COST_W] == '0)
    else $error("nonzero cost on a pixel that is not last");

  // the input side only stops taking items right after it took one
  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(s_tready) |-> $past(s_tvalid))
    else $error("input ready dropped without an accepted item");

endmodule

bind masked_ssd_cost_and_force_top mssd_checker u_mssd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

@@ sim/masked_ssd_cost_and_force_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_ssd_cost_and_force_top_tb - self-checking bench for the SSD cost block
// Streams pixel pairs with a mask bit and gradients through the block.
// Mirrors the Q16.16 force and the Q.8 cost in a local predictor and compares
// every result field. The image size is written over APB between phases.
// ----------------------------------------------------------------------------
module masked_ssd_cost_and_force_top_tb;
  import mssd_pkg::*;

  localparam int PB          = DEF_PIXEL_BITS;
  localparam int SIZE_W      = DEF_COUNT_BITS + 1;
  localparam int IN_W        = in_tdata_width(PB);
  localparam int RANDOM_PIX  = 1700;
  localparam int HOLD_CYCLES = 1000;
  localparam int SETTLE      = 300;
  localparam int CYCLE_LIMIT = 2_500_000;
  localparam logic [PADDR_W-1:0] SIZE_ADDR = {REG_IMAGE_SIZE, 2'b00};

  typedef struct {
    logic signed [PB-1:0]     pix_a, pix_b;
    logic signed [GRAD_W-1:0] gx, gy, gz;
    logic                     mask_on, last;
  } pixel_t;

  typedef struct {
    logic [FORCE_W-1:0] fx, fy, fz;
    logic [COST_W-1:0]  cost;
    logic               done;
  } ssd_result_t;

  // Scoreboard: own copy of the running sum and image size, plus the
  // queue of results still owed by the block.
  class ssd_scoreboard;
    logic [SUM_W-1:0]  square_sum;
    logic [SIZE_W-1:0] image_size;
    ssd_result_t       owed_q[$];
    int fails, results_seen, frames_closed, pixels_noted, masked_noted;

    function new();
      square_sum    = '0;
      image_size    = '0;
      fails         = 0;
      results_seen  = 0;
      frames_closed = 0;
      pixels_noted  = 0;
      masked_noted  = 0;
    endfunction

    function void set_size(logic [PDATA_W-1:0] n);
      image_size = n[SIZE_W-1:0];
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // grad * delta / n in Q16.16, truncated toward zero, then clamped
    function logic [FORCE_W-1:0] force_of(logic signed [GRAD_W-1:0] g, longint d);
      longint          prod;
      longint unsigned mag, quo;
      if (image_size == 0) return '0;
      prod = longint'(g) * d;
      mag  = (prod < 0) ? -prod : prod;
      quo  = (mag << FORCE_SHIFT) / image_size;
      if (prod < 0) begin
        if (quo > 64'h8000_0000) return FORCE_NEG_LIM;
        quo = -quo;
        return quo[FORCE_W-1:0];
      end
      if (quo > 64'h7FFF_FFFF) return FORCE_POS_LIM;
      return quo[FORCE_W-1:0];
    endfunction

    // floor(0.5 * sum * 256 / n), clamped to the cost width
    function logic [COST_W-1:0] cost_of(logic [SUM_W-1:0] sum);
      logic [SUM_W+COST_SHIFT-1:0] scaled;
      if (image_size == 0) return '0;
      scaled = {sum, {COST_SHIFT{1'b0}}};
      scaled = scaled / image_size;
      if (scaled > {COST_W{1'b1}}) return '1;
      return scaled[COST_W-1:0];
    endfunction

    function void note_pixel(pixel_t p);
      ssd_result_t     r;
      longint          d;
      longint unsigned sq;
      logic [SUM_W:0]  acc;
      r.fx   = '0;
      r.fy   = '0;
      r.fz   = '0;
      r.cost = '0;
      r.done = p.last;
      pixels_noted++;
      if (p.mask_on) begin
        masked_noted++;
        d    = longint'(p.pix_a) - longint'(p.pix_b);
        r.fx = force_of(p.gx, d);
        r.fy = force_of(p.gy, d);
        r.fz = force_of(p.gz, d);
        sq   = d * d;
        acc  = {1'b0, square_sum} + (SUM_W + 1)'(sq);
        square_sum = acc[SUM_W] ? '1 : acc[SUM_W-1:0];
      end
      if (p.last) begin
        r.cost     = cost_of(square_sum);
        square_sum = '0;
      end
      owed_q.push_back(r);
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        fails++;
        if (fails <= 10)
          $display("[%0t] %s mismatch: expected %0h, got %0h", $time, field, want, got);
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] data, logic tlast);
      ssd_result_t e;
      results_seen++;
      if (owed_q.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("[%0t] result %0h arrived with nothing outstanding", $time, data);
        return;
      end
      e = owed_q.pop_front();
      if (e.done) frames_closed++;
      compare("force_x", 64'(e.fx), 64'(data[FORCE_W-1:0]));
      compare("force_y", 64'(e.fy), 64'(data[2*FORCE_W-1:FORCE_W]));
      compare("force_z", 64'(e.fz), 64'(data[3*FORCE_W-1:2*FORCE_W]));
      compare("cost_value", 64'(e.cost), 64'(data[3*FORCE_W+COST_W-1:3*FORCE_W]));
      compare("cost_ready", 64'(e.done), 64'(tlast));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  // s_tdata, low to high: pixel_a, pixel_b, grad_x, grad_y, grad_z
  logic [IN_W-1:0]        s_tdata;
  // s_tuser: mask_on
  logic                   s_tuser;
  logic                   s_tlast;
  logic                   m_tvalid;
  logic                   m_tready;
  // m_tdata, low to high: force_x, force_y, force_z, cost_value
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;
  logic                   psel, penable, pwrite;
  logic [PADDR_W-1:0]     paddr;
  logic [PDATA_W-1:0]     pwdata, prdata;
  logic                   pready;

  ssd_scoreboard sb;
  int  cycles = 0;
  int  held_stalls = 0;
  int  sizes_used = 0;
  bit  calm = 1'b0;          // last part of the run: no idling on either side
  bit  feed_idle_en = 1'b1;
  bit  sink_idle_en = 1'b1;
  bit  hold_req = 1'b0;      // ask the sink for one long hold-off
  bit  holding = 1'b0;

  masked_ssd_cost_and_force_top #(
    .PIXEL_BITS(PB),
    .COUNT_BITS(DEF_COUNT_BITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Count cycles, note input stalls caused by the hold-off, and give up
  // if the run hangs.
  always @(posedge clk) begin
    cycles++;
    if (holding && s_tvalid && !s_tready) held_stalls++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("FAILURE");
      $finish;
    end
  end

  // Check every result item the moment it is taken.
  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready)
      sb.check_result(m_tdata, m_tlast);
  end

  // Result side: accept by default, stall in random bursts, and once hold
  // off for a long stretch so the block backs up into its input.
  initial begin : sink
    m_tready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_req) begin
        holding = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding  = 1'b0;
        hold_req = 1'b0;
      end else if (!calm && sink_idle_en && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // One APB transfer: setup phase, access phase until pready, then an idle
  // phase, so a following transfer never drives psel twice in the same step.
  task automatic reg_access(input bit wr, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Write the image size, mirror it, and read it back.
  task automatic set_image_size(input logic [PDATA_W-1:0] n);
    logic [PDATA_W-1:0] rd;
    reg_access(1'b1, SIZE_ADDR, n, rd);
    sb.set_size(n);
    reg_access(1'b0, SIZE_ADDR, '0, rd);
    sb.compare("image_size", 64'(n[SIZE_W-1:0]), 64'(rd));
    sizes_used++;
  endtask

  // Offer one pixel item, hold it until taken, then maybe idle a burst.
  task automatic feed(input pixel_t p);
    s_tdata  <= IN_W'({p.gz, p.gy, p.gx, p.pix_b, p.pix_a});
    s_tuser  <= p.mask_on;
    s_tlast  <= p.last;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (s_tready !== 1'b1);
    sb.note_pixel(p);
    if (!calm && feed_idle_en && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic pixel_t pix(logic [PB-1:0] a, logic [PB-1:0] b, bit m,
                                 logic [GRAD_W-1:0] gx, logic [GRAD_W-1:0] gy,
                                 logic [GRAD_W-1:0] gz, bit last);
    pixel_t p;
    p.pix_a   = a;
    p.pix_b   = b;
    p.mask_on = m;
    p.gx      = gx;
    p.gy      = gy;
    p.gz      = gz;
    p.last    = last;
    return p;
  endfunction

  // Favor the edges of the signed range, otherwise anything.
  function automatic logic [PB-1:0] any_value();
    case ($urandom_range(0, 9))
      0: return {1'b0, {(PB-1){1'b1}}};
      1: return {1'b1, {(PB-1){1'b0}}};
      2: return '0;
      3: return '1;
      4: return PB'(1);
      default: return PB'($urandom);
    endcase
  endfunction

  function automatic pixel_t rand_pixel(bit last);
    pixel_t p;
    p.pix_a = any_value();
    // half the time keep the pair close, as in a registered image
    if ($urandom_range(0, 1))
      p.pix_b = any_value();
    else
      p.pix_b = p.pix_a + PB'($urandom_range(0, 64)) - PB'(32);
    p.mask_on = ($urandom_range(0, 9) < 8);
    p.gx      = any_value();
    p.gy      = any_value();
    p.gz      = ($urandom_range(0, 4) == 0) ? '0 : any_value();
    p.last    = last;
    return p;
  endfunction

  function automatic logic [PDATA_W-1:0] pick_size();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 32'd1;
      2: return 32'd1 << DEF_COUNT_BITS;
      3: return $urandom_range(2, 16);
      4: return $urandom_range(17, 4096);
      5: return $urandom_range(4097, 1 << 20);
      default: return $urandom_range(1, 1 << DEF_COUNT_BITS);
    endcase
  endfunction

  initial begin : stimulus
    int phase;
    int phase_items;
    int done_items;
    int frame_len;
    sb       = new();
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = 1'b0;
    s_tlast  = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Size is zero out of reset: forces and cost are zero, but the sum
    // still builds up and is cleared by the last pixel.
    feed(pix(16'h7FFF, 16'h8000, 1, 16'h7FFF, 16'h8000, 16'h0001, 0));
    feed(pix(16'h1234, 16'h0034, 1, 16'h0100, 16'hFF00, 16'h0000, 1));
    drain();

    // Size one: widest deltas drive the forces into both clamps and the
    // cost past its top.
    set_image_size(1);
    feed(pix(16'h7FFF, 16'h8000, 1, 16'h8000, 16'h7FFF, 16'h0000, 0));
    feed(pix(16'h8000, 16'h7FFF, 1, 16'h8000, 16'h7FFF, 16'hFFFF, 0));
    feed(pix(16'h7FFF, 16'h8000, 1, 16'h0001, 16'hFFFF, 16'h7FFF, 1));
    // delta of +/-256 against the most negative gradient: one lands exactly
    // on the negative limit, the other just past the positive one
    feed(pix(16'h0100, 16'h0000, 1, 16'h8000, 16'h7FFF, 16'h0001, 0));
    feed(pix(16'h0000, 16'h0100, 1, 16'h8000, 16'h7FFF, 16'hFFFF, 0));
    // unmasked pixels give no force and leave the sum alone
    feed(pix(16'h7FFF, 16'h8000, 0, 16'h7FFF, 16'h8000, 16'h7FFF, 1));
    feed(pix(16'h4000, 16'hC000, 0, 16'h1111, 16'h2222, 16'h3333, 1));
    feed(pix(16'h5555, 16'h5555, 1, 16'h7FFF, 16'h8000, 16'hFFFF, 1));
    drain();

    // Size 1 << DEF_COUNT_BITS, the largest that the bench picks.
    set_image_size(32'd1 << DEF_COUNT_BITS);
    feed(pix(16'h7FFF, 16'h8000, 1, 16'h7FFF, 16'h8000, 16'h0001, 0));
    feed(pix(16'h8000, 16'h7FFF, 1, 16'h8000, 16'h7FFF, 16'hFFFF, 1));
    drain();

    // Size three: truncation toward zero on both signs.
    set_image_size(3);
    feed(pix(16'h0001, 16'h0000, 1, 16'h0001, 16'hFFFF, 16'h0000, 0));
    feed(pix(16'h0000, 16'h0001, 1, 16'h0001, 16'hFFFF, 16'h0002, 0));
    feed(pix(16'hFFFF, 16'h0001, 1, 16'h00FF, 16'hFF01, 16'h0000, 1));

    // Random phases of whole images, a new size between phases.
    phase      = 0;
    done_items = 0;
    while (done_items < RANDOM_PIX) begin
      drain();
      set_image_size(pick_size());
      feed_idle_en = ($urandom_range(0, 3) != 0);
      sink_idle_en = ($urandom_range(0, 3) != 0);
      if (phase == 2) hold_req = 1'b1;
      if (done_items > RANDOM_PIX * 4 / 5) calm = 1'b1;
      phase_items = $urandom_range(60, 160);
      while (phase_items > 0 && done_items < RANDOM_PIX) begin
        frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 12);
        for (int j = 0; j < frame_len; j++)
          feed(rand_pixel(j == frame_len - 1));
        phase_items -= frame_len;
        done_items  += frame_len;
      end
      phase++;
    end

    // Let the pipeline run dry; any stray result fails in the scoreboard.
    drain();
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d pixels (%0d masked), %0d images closed, %0d size settings",
             sb.pixels_noted, sb.masked_noted, sb.frames_closed, sizes_used);
    $display("compared %0d results; the long hold-off stalled the input %0d cycles",
             sb.results_seen, held_stalls);
    if (sb.fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d check(s) failed", sb.fails);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
